### design/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the parser RTL.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/acp_pkg.sv
// ------------------------------------------------------------------------
// Archive container parser package
// Types, codes and header constants shared by the parser modules.
// ------------------------------------------------------------------------
`default_nettype none

package acp_pkg;

	// Header layout
	localparam int unsigned HdrBytes   = 28;
	localparam int unsigned VerStart   = 8;
	localparam int unsigned TextStart  = 12;
	localparam int unsigned PkgStart   = 20;
	localparam int unsigned IdxW       = 5;

	// Section codes
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_TEXT    = 2'd1;
	localparam logic [1:0] PH_PACKAGE = 2'd2;
	localparam logic [1:0] PH_SURPLUS = 2'd3;

	// Status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_MAGIC   = 3'd1;
	localparam logic [2:0] ST_VERSION = 3'd2;
	localparam logic [2:0] ST_ZERO    = 3'd3;
	localparam logic [2:0] ST_TRUNC   = 3'd4;
	localparam logic [2:0] ST_TRAIL   = 3'd5;

	// Packed output data width: byte, status, two lengths, padded to bytes
	localparam int unsigned OutDataBits = 8 + 3 + 64 + 64;
	localparam int unsigned OutDataW    = ((OutDataBits + 7) / 8) * 8;

	typedef struct packed {
		logic [63:0] package_length;
		logic [63:0] text_length;
		logic [2:0]  status;
		logic        image_end;
		logic [1:0]  section;
		logic [7:0]  byte_out;
	} acp_result_t;

	// Expected magic byte "LRARCH1\0" at a header position
	function automatic logic [7:0] magic_byte(input logic [2:0] pos);
		logic [7:0] val;
		unique case (pos)
			3'd0: val = 8'h4C;
			3'd1: val = 8'h52;
			3'd2: val = 8'h41;
			3'd3: val = 8'h52;
			3'd4: val = 8'h43;
			3'd5: val = 8'h48;
			3'd6: val = 8'h31;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

### design/acp_core.sv
// ------------------------------------------------------------------------
// Archive parser core
// Header checks, section counting and first-error tracking, one byte per
// accepted item.
// ------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module acp_core
	import acp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_fire,
	input  wire logic [7:0]  stream_byte,
	input  wire logic        final_byte,
	output acp_result_t      result
);

	logic [IdxW-1:0] hdr_idx_q, hdr_idx_d;
	logic [1:0]      phase_q, phase_d;
	logic [2:0]      err_q, err_d;
	logic [63:0]     text_len_q, text_len_d;
	logic [63:0]     pkg_len_q, pkg_len_d;
	logic [63:0]     remain_q, remain_d;
	logic [63:0]     remain_dec;
	logic [IdxW-1:0] text_pos, pkg_pos;

	assign remain_dec = remain_q - 64'd1;
	assign text_pos   = hdr_idx_q - IdxW'(TextStart);
	assign pkg_pos    = hdr_idx_q - IdxW'(PkgStart);

	// Work out next state and the result for the byte on the input
	always_comb begin
		hdr_idx_d  = hdr_idx_q;
		phase_d    = phase_q;
		err_d      = err_q;
		text_len_d = text_len_q;
		pkg_len_d  = pkg_len_q;
		remain_d   = remain_q;

		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_idx_q < IdxW'(VerStart)) begin
					if (stream_byte != magic_byte(hdr_idx_q[2:0]) && err_d == ST_OK)
						err_d = ST_MAGIC;
				end else if (hdr_idx_q < IdxW'(TextStart)) begin
					if (stream_byte != ((hdr_idx_q == IdxW'(VerStart)) ? 8'd1 : 8'd0)
						&& err_d == ST_OK)
						err_d = ST_VERSION;
				end else if (hdr_idx_q < IdxW'(PkgStart)) begin
					for (int k = 0; k < 8; k++) begin
						if (text_pos[2:0] == 3'(k))
							text_len_d[k*8 +: 8] = text_len_q[k*8 +: 8] | stream_byte;
					end
				end else begin
					for (int k = 0; k < 8; k++) begin
						if (pkg_pos[2:0] == 3'(k))
							pkg_len_d[k*8 +: 8] = pkg_len_q[k*8 +: 8] | stream_byte;
					end
				end
				if (hdr_idx_q == IdxW'(HdrBytes - 1)) begin
					hdr_idx_d = '0;
					if ((text_len_d == 64'd0 || pkg_len_d == 64'd0) && err_d == ST_OK)
						err_d = ST_ZERO;
					if (text_len_d != 64'd0) begin
						phase_d  = PH_TEXT;
						remain_d = text_len_d;
					end else if (pkg_len_d != 64'd0) begin
						phase_d  = PH_PACKAGE;
						remain_d = pkg_len_d;
					end else begin
						phase_d = PH_SURPLUS;
					end
				end else begin
					hdr_idx_d = hdr_idx_q + IdxW'(1);
				end
			end
			PH_TEXT: begin
				remain_d = remain_dec;
				if (remain_dec == 64'd0) begin
					if (pkg_len_q != 64'd0) begin
						phase_d  = PH_PACKAGE;
						remain_d = pkg_len_q;
					end else begin
						phase_d = PH_SURPLUS;
					end
				end
			end
			PH_PACKAGE: begin
				remain_d = remain_dec;
				if (remain_dec == 64'd0)
					phase_d = PH_SURPLUS;
			end
			default: begin
				if (err_d == ST_OK)
					err_d = ST_TRAIL;
			end
		endcase

		result.byte_out  = stream_byte;
		result.section   = phase_q;
		result.image_end = final_byte;
		if (final_byte) begin
			if (phase_d != PH_SURPLUS && err_d == ST_OK)
				err_d = ST_TRUNC;
			result.status         = err_d;
			result.text_length    = text_len_d;
			result.package_length = pkg_len_d;
			// Return to the reset state for the next image
			hdr_idx_d  = '0;
			phase_d    = PH_HEADER;
			err_d      = ST_OK;
			text_len_d = '0;
			pkg_len_d  = '0;
			remain_d   = '0;
		end else begin
			result.status         = ST_OK;
			result.text_length    = '0;
			result.package_length = '0;
		end
	end

	// Advance state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q  <= '0;
			phase_q    <= PH_HEADER;
			err_q      <= ST_OK;
			text_len_q <= '0;
			pkg_len_q  <= '0;
			remain_q   <= '0;
		end else if (in_fire) begin
			hdr_idx_q  <= hdr_idx_d;
			phase_q    <= phase_d;
			err_q      <= err_d;
			text_len_q <= text_len_d;
			pkg_len_q  <= pkg_len_d;
			remain_q   <= remain_d;
		end
	end

	`ASSERT_CLK(a_hdr_idx_range, hdr_idx_q < IdxW'(HdrBytes), "header index out of range")
	`ASSERT_CLK(a_hdr_idx_idle, phase_q != PH_HEADER |-> hdr_idx_q == '0, "header index not cleared")
	`ASSERT_CLK(a_end_resets, in_fire && final_byte |=> phase_q == PH_HEADER && err_q == ST_OK, "no reset after image end")

endmodule

`default_nettype wire

### design/archive_container_parser.sv
// ------------------------------------------------------------------------
// Archive container parser
// Streams an archive image byte by byte, checks its header and labels each
// byte with the section it belongs to.
// ------------------------------------------------------------------------
// Usage:
//   s_tdata[7:0] carries one image byte, s_tlast marks the final byte.
//   Every accepted byte gives exactly one result on the m_ side: the byte,
//   its section on m_tuser, m_tlast on the final byte, and on that final
//   byte the status and both header lengths (zero on other bytes).
//   Each result is registered in the output or skid register. Throughput is one
//   byte per cycle while s_tready is high; the per-byte work is a byte compare
//   and a 64-bit decrement with zero test on the section counter.
//   The output register is backed by a one-entry skid register, so an item
//   is still taken in the cycle the receiver first stalls; s_tready drops
//   only while the skid register is full.
//   Reset clears the parser to the header phase with no error held and
//   empties both output registers. After the final byte of an image the
//   parser returns to that same state, ready for the next image.
// ------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module archive_container_parser
	import acp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,   // [7:0] stream_byte
	input  wire logic                s_tlast,   // final_byte
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// [7:0] byte_out, [10:8] status, [74:11] text_length,
	// [138:75] package_length, [143:139] zero
	output logic [OutDataW-1:0]      m_tdata,
	output logic [1:0]               m_tuser,   // section
	output logic                     m_tlast    // image_end
);

	acp_result_t res;
	acp_result_t out_q, skid_q;
	logic        out_valid_q, skid_valid_q;
	logic        in_fire;

	assign s_tready = !skid_valid_q;
	assign in_fire  = s_tvalid && s_tready;

	acp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.stream_byte (s_tdata),
		.final_byte  (s_tlast),
		.result      (res)
	);

	// Hold results in the output register, overflow into the skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves with the valid flags
	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (in_fire)
				out_q <= res;
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.section;
	assign m_tlast  = out_q.image_end;
	assign m_tdata  = {(OutDataW - OutDataBits)'(0), out_q.package_length,
		out_q.text_length, out_q.status, out_q.byte_out};

	`ASSERT_CLK(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
	`ASSERT_CLK(a_skid_fill, out_valid_q && !m_tready && in_fire |=> skid_valid_q, "stalled item lost")

endmodule

`default_nettype wire
